FILE: hdl/owsc_pkg.sv
// Package for the 1-wire slot codec: opcodes, result kinds, status codes,
// register indexes, sequencer states, reset values and the result record.
// No dependencies.
package owsc_pkg;

  localparam int MaxSlots = 128;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 32;
  localparam int OutDataW = 32;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_SEND     = 3'd1,
    OP_READ     = 3'd2,
    OP_BIT      = 3'd3,
    OP_PRESENCE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_PULSE    = 2'd0,
    KIND_BIT      = 2'd1,
    KIND_PRESENCE = 2'd2,
    KIND_STATUS   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OVERFLOW   = 2'd1,
    ST_ZERO_COUNT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_ONE_PULSE  = 3'd0,
    REG_ZERO_PULSE = 3'd1,
    REG_READ_PULSE = 3'd2,
    REG_BIT_BAR    = 3'd3,
    REG_PRES_BAR   = 3'd4
  } reg_e;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_SLOT = 1'b1
  } seq_e;

  localparam logic [15:0] OnePulseRst  = 16'd10;
  localparam logic [15:0] ZeroPulseRst = 16'd60;
  localparam logic [15:0] ReadPulseRst = 16'd3;
  localparam logic [15:0] BitBarRst    = 16'd15;
  localparam logic [15:0] PresBarRst   = 16'd550;

  localparam logic [7:0] BitLsb = 8'h01;
  localparam logic [7:0] BitMsb = 8'h80;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] pulse_width;
    logic        bit_value;
    logic [7:0]  byte_value;
    logic        byte_done;
    logic        present;
    status_e     status;
    logic        last;
  } res_t;

endpackage

FILE: hdl/onewire_slot_codec_unit.sv
// 1-wire bus master slot codec: turns bytes into slot pulse widths and
// decodes captured widths into bits, bytes and presence.
// Depends on owsc_pkg.
// Single-result items go straight into the output register on acceptance; sends and reads
// first enter the slot state, which then emits one slot per cycle while the consumer takes
// results (read count saturated at 8 bytes), and stops early with an overflow status. No new
// item is accepted until the slot state is left; a result waiting on the consumer stalls it.
// Reset: rst_ni low clears slot count, receive shift state, the sequencer state and the
// output valid flag, and loads the timing registers with their default values.
module onewire_slot_codec_unit
  import owsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input items
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata: [7:0] data_byte, [11:8] read_count, [27:12] capture_width, [31:28] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // tuser: [2:0] opcode
  input  logic [2:0]          s_axis_tuser_i,
  // result items
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tdata: [15:0] pulse_width, [16] bit_value, [24:17] byte_value, [25] byte_done,
  //        [26] present, [28:27] status, [31:29] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // tuser: [1:0] kind
  output logic [1:0]          m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  // timing and barrier registers
  logic [15:0] one_pw_q, zero_pw_q, read_pw_q, bit_bar_q, pres_bar_q;

  // block state
  logic [7:0] slot_count_q, slot_count_d;
  logic [7:0] rx_shift_q, rx_shift_d;
  logic [2:0] rx_idx_q, rx_idx_d;

  // slot sequencer
  seq_e       seq_q, seq_d;
  logic       send_mode_q, send_mode_d;   // 1: write slots, 0: read slots
  logic [7:0] tx_shift_q, tx_shift_d;
  logic [6:0] slots_left_q, slots_left_d;

  // output register
  logic out_valid_q, out_valid_d;
  res_t res_q, res_d;

  // input fields
  op_e         opcode;
  logic [7:0]  data_byte;
  logic [3:0]  read_count;
  logic [15:0] capture_width;
  logic [3:0]  read_bytes;

  logic out_free, in_accept, overflow;

  // shared magnitude compare
  logic [15:0] cmp_a, cmp_b;
  logic        cmp_lt;

  assign opcode        = op_e'(s_axis_tuser_i);
  assign data_byte     = s_axis_tdata_i[7:0];
  assign read_count    = s_axis_tdata_i[11:8];
  assign capture_width = s_axis_tdata_i[27:12];
  assign read_bytes    = (read_count > 4'd8) ? 4'd8 : read_count;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (seq_q == SEQ_IDLE) && out_free;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign overflow        = slot_count_q >= 8'(MaxSlots);
  assign cfg_ready_o     = 1'b1;

  // Select the barrier for the capture kind; presence uses the inverted result.
  assign cmp_a  = capture_width;
  assign cmp_b  = (opcode == OP_PRESENCE) ? pres_bar_q : bit_bar_q;
  assign cmp_lt = cmp_a < cmp_b;

  // Configuration registers: drop writes beyond the register list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_pw_q   <= OnePulseRst;
      zero_pw_q  <= ZeroPulseRst;
      read_pw_q  <= ReadPulseRst;
      bit_bar_q  <= BitBarRst;
      pres_bar_q <= PresBarRst;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_ONE_PULSE:  one_pw_q   <= cfg_data_i;
        REG_ZERO_PULSE: zero_pw_q  <= cfg_data_i;
        REG_READ_PULSE: read_pw_q  <= cfg_data_i;
        REG_BIT_BAR:    bit_bar_q  <= cfg_data_i;
        REG_PRES_BAR:   pres_bar_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state of the slot sequencer.
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SEQ_IDLE: begin
        if (in_accept && (opcode == OP_SEND ||
                          (opcode == OP_READ && read_count != 4'd0))) begin
          seq_d = SEQ_SLOT;
        end
      end
      SEQ_SLOT: begin
        // leave after the final slot or on overflow
        if (out_free && (overflow || slots_left_q == 7'd1)) begin
          seq_d = SEQ_IDLE;
        end
      end
      default: seq_d = SEQ_IDLE;
    endcase
  end

  // Results and state updates.
  always_comb begin
    slot_count_d = slot_count_q;
    rx_shift_d   = rx_shift_q;
    rx_idx_d     = rx_idx_q;
    send_mode_d  = send_mode_q;
    tx_shift_d   = tx_shift_q;
    slots_left_d = slots_left_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    res_d        = res_q;

    unique case (seq_q)
      SEQ_IDLE: begin
        if (in_accept) begin
          res_d      = '0;
          res_d.last = 1'b1;
          unique case (opcode)
            OP_CLEAR: begin
              slot_count_d = '0;
              rx_shift_d   = '0;
              rx_idx_d     = '0;
              res_d.kind   = KIND_STATUS;
              res_d.status = ST_OK;
              out_valid_d  = 1'b1;
            end
            OP_SEND: begin
              send_mode_d  = 1'b1;
              tx_shift_d   = data_byte;
              slots_left_d = 7'd8;
            end
            OP_READ: begin
              if (read_count == 4'd0) begin
                res_d.kind   = KIND_STATUS;
                res_d.status = ST_ZERO_COUNT;
                out_valid_d  = 1'b1;
              end else begin
                send_mode_d  = 1'b0;
                slots_left_d = {read_bytes, 3'b000};
              end
            end
            OP_BIT: begin
              // shift in at the MSB so the byte assembles LSB first
              rx_shift_d       = (rx_shift_q >> 1) | (cmp_lt ? BitMsb : 8'h00);
              rx_idx_d         = rx_idx_q + 3'd1;
              res_d.kind       = KIND_BIT;
              res_d.bit_value  = cmp_lt;
              res_d.byte_value = rx_shift_d;
              res_d.byte_done  = (rx_idx_q == 3'd7);
              out_valid_d      = 1'b1;
            end
            OP_PRESENCE: begin
              res_d.kind    = KIND_PRESENCE;
              res_d.present = !cmp_lt;
              out_valid_d   = 1'b1;
            end
            default: ;  // unknown opcodes: accept and ignore
          endcase
        end
      end
      SEQ_SLOT: begin
        if (out_free) begin
          res_d       = '0;
          out_valid_d = 1'b1;
          if (overflow) begin
            res_d.kind   = KIND_STATUS;
            res_d.status = ST_OVERFLOW;
            res_d.last   = 1'b1;
          end else begin
            slot_count_d = slot_count_q + 8'd1;
            slots_left_d = slots_left_q - 7'd1;
            tx_shift_d   = tx_shift_q >> 1;
            res_d.kind   = KIND_PULSE;
            res_d.last   = (slots_left_q == 7'd1);
            if (!send_mode_q) begin
              res_d.pulse_width = read_pw_q;
            end else if ((tx_shift_q & BitLsb) != 8'h00) begin
              res_d.pulse_width = one_pw_q;
            end else begin
              res_d.pulse_width = zero_pw_q;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= SEQ_IDLE;
      slot_count_q <= '0;
      rx_shift_q   <= '0;
      rx_idx_q     <= '0;
      slots_left_q <= '0;
      send_mode_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      seq_q        <= seq_d;
      slot_count_q <= slot_count_d;
      rx_shift_q   <= rx_shift_d;
      rx_idx_q     <= rx_idx_d;
      slots_left_q <= slots_left_d;
      send_mode_q  <= send_mode_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    tx_shift_q <= tx_shift_d;
    res_q      <= res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.kind;
  assign m_axis_tlast_o  = res_q.last;
  assign m_axis_tdata_o  = {3'b000, res_q.status, res_q.present, res_q.byte_done,
                            res_q.byte_value, res_q.bit_value, res_q.pulse_width};

endmodule

FILE: test/onewire_slot_codec_unit_tb.sv
// Self-checking testbench for onewire_slot_codec_unit: a directed stimulus table, then
// random traffic under several timing settings and stall patterns, checked item by item.
// Depends on owsc_pkg and the codec RTL.
module testbench;
  import owsc_pkg::*;

  localparam int HalfPeriod    = 10;
  localparam int ResetCycles   = 5;
  localparam int IdleLimit     = 5000;
  localparam int QuietCycles   = 8;
  localparam int ItemsPerPhase = 70;
  localparam int NumPhases     = 4;
  localparam int SlotsPerByte  = 8;
  localparam int MaxReadBytes  = 8;

  localparam logic [2:0]  OpFirstUnused = 3'd5;
  localparam logic [2:0]  OpMidUnused   = 3'd6;
  localparam logic [2:0]  OpLastUnused  = 3'd7;
  localparam logic [15:0] WidthMax      = 16'hFFFF;
  localparam res_t        NoRes         = '0;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  data;
    logic [3:0]  cnt;
    logic [15:0] cap;
    bit          typed;
    res_t        want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic [2:0]          s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;
  logic                m_axis_tlast_o;

  // Codec state as the testbench sees it.
  logic [15:0] one_w = OnePulseRst;
  logic [15:0] zero_w = ZeroPulseRst;
  logic [15:0] read_w = ReadPulseRst;
  logic [15:0] bit_bar = BitBarRst;
  logic [15:0] pres_bar = PresBarRst;
  logic [7:0]  slots_used = '0;
  logic [7:0]  rx_byte = '0;
  logic [2:0]  rx_bits = '0;

  res_t        awaited_results[$];
  res_t        item_results[$];
  stim_row_t   directed[$];

  int          sender_idle_pct = 0;
  int          stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  onewire_slot_codec_unit dut (.*);

  always #HalfPeriod clk_i = ~clk_i;

  function automatic res_t status_res(status_e st);
    res_t r = '0;
    r.kind   = KIND_STATUS;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic res_t presence_res(logic pr);
    res_t r = '0;
    r.kind    = KIND_PRESENCE;
    r.present = pr;
    r.last    = 1'b1;
    return r;
  endfunction

  function automatic res_t bit_res(logic b, logic [7:0] byt, logic dn);
    res_t r = '0;
    r.kind       = KIND_BIT;
    r.bit_value  = b;
    r.byte_value = byt;
    r.byte_done  = dn;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t stim(logic [2:0] op, logic [7:0] data, logic [3:0] cnt,
                                     logic [15:0] cap, bit typed = 1'b0, res_t want = NoRes);
    stim_row_t row;
    row.op    = op;
    row.data  = data;
    row.cnt   = cnt;
    row.cap   = cap;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  // Queue one bus slot; once the slot budget is spent, close the item with an overflow.
  function automatic bit queue_slot(logic [15:0] w, bit final_slot);
    res_t r = '0;
    if (slots_used >= MaxSlots) begin
      item_results.push_back(status_res(ST_OVERFLOW));
      return 1'b0;
    end
    slots_used    = slots_used + 8'd1;
    r.kind        = KIND_PULSE;
    r.pulse_width = w;
    r.last        = final_slot;
    item_results.push_back(r);
    return 1'b1;
  endfunction

  // Work out the results of one accepted item into item_results.
  task automatic codec_item(logic [2:0] op, logic [7:0] data, logic [3:0] cnt,
                            logic [15:0] cap);
    int unsigned n;
    logic        b;
    item_results.delete();
    case (op)
      OP_CLEAR: begin
        slots_used = '0;
        rx_byte    = '0;
        rx_bits    = '0;
        item_results.push_back(status_res(ST_OK));
      end
      OP_SEND: begin
        for (int i = 0; i < SlotsPerByte; i++) begin
          if (!queue_slot(data[i] ? one_w : zero_w, i == SlotsPerByte - 1)) return;
        end
      end
      OP_READ: begin
        if (cnt == '0) begin
          item_results.push_back(status_res(ST_ZERO_COUNT));
        end else begin
          n = ((cnt > MaxReadBytes) ? MaxReadBytes : cnt) * SlotsPerByte;
          for (int i = 0; i < n; i++) begin
            if (!queue_slot(read_w, i == n - 1)) return;
          end
        end
      end
      OP_BIT: begin
        b       = cap < bit_bar;
        rx_byte = {b, rx_byte[7:1]};
        rx_bits = rx_bits + 3'd1;
        item_results.push_back(bit_res(b, rx_byte, rx_bits == '0));
      end
      OP_PRESENCE: item_results.push_back(presence_res(cap >= pres_bar));
      default: ;
    endcase
  endtask

  // Offer one item, idling first at the phase's rate; predict once it is taken.
  task automatic push_item(logic [2:0] op, logic [7:0] data, logic [3:0] cnt,
                           logic [15:0] cap);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {4'b0, cap, cnt, data};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    codec_item(op, data, cnt, cap);
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_ONE_PULSE:  one_w = val;
      REG_ZERO_PULSE: zero_w = val;
      REG_READ_PULSE: read_w = val;
      REG_BIT_BAR:    bit_bar = val;
      REG_PRES_BAR:   pres_bar = val;
      default: ;
    endcase
  endtask

  task automatic load_timing(logic [15:0] one, logic [15:0] zero, logic [15:0] rd,
                             logic [15:0] bb, logic [15:0] pb);
    write_reg(REG_ONE_PULSE, one);
    write_reg(REG_ZERO_PULSE, zero);
    write_reg(REG_READ_PULSE, rd);
    write_reg(REG_BIT_BAR, bb);
    write_reg(REG_PRES_BAR, pb);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold off input until every awaited result is out, then idle for the QuietCycles period.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Receiver side: stall at the phase's rate.
  always @(posedge clk_i) m_axis_tready_i <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_results.size() == 0) begin
        $error("result with none awaited: kind %0d tdata %h", m_axis_tuser_o, m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", want.kind, m_axis_tuser_o);
        check_field("pulse_width", want.pulse_width, m_axis_tdata_o[15:0]);
        check_field("bit_value", want.bit_value, m_axis_tdata_o[16]);
        check_field("byte_value", want.byte_value, m_axis_tdata_o[24:17]);
        check_field("byte_done", want.byte_done, m_axis_tdata_o[25]);
        check_field("present", want.present, m_axis_tdata_o[26]);
        check_field("status", want.status, m_axis_tdata_o[28:27]);
        check_field("last", want.last, m_axis_tlast_o);
      end
    end
  end

  // Watchdog: end the run when no channel has moved an item for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IdleLimit) begin
      $display("onewire_slot_codec_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned accepted;
    int unsigned pick;
    logic [2:0]  op;
    logic [7:0]  data;
    logic [3:0]  cnt;
    logic [15:0] cap;
    logic [15:0] bar;

    // Defaults after reset: one 10, zero 60, read 3, bit barrier 15, presence barrier 550.
    directed = '{
      stim(OP_CLEAR, 8'h00, 4'd0, 16'd0, 1'b1, status_res(ST_OK)),
      stim(OP_READ, 8'h00, 4'd0, 16'd0, 1'b1, status_res(ST_ZERO_COUNT)),
      stim(OP_PRESENCE, 8'h00, 4'd0, 16'd0, 1'b1, presence_res(1'b0)),
      stim(OP_PRESENCE, 8'h00, 4'd0, PresBarRst - 16'd1, 1'b1, presence_res(1'b0)),
      stim(OP_PRESENCE, 8'h00, 4'd0, PresBarRst, 1'b1, presence_res(1'b1)),
      stim(OP_PRESENCE, 8'h00, 4'd0, WidthMax, 1'b1, presence_res(1'b1)),
      stim(OP_BIT, 8'h00, 4'd0, BitBarRst - 16'd1, 1'b1, bit_res(1'b1, 8'h80, 1'b0)),
      stim(OP_BIT, 8'h00, 4'd0, BitBarRst, 1'b1, bit_res(1'b0, 8'h40, 1'b0)),
      stim(OP_BIT, 8'h00, 4'd0, 16'd0, 1'b1, bit_res(1'b1, 8'hA0, 1'b0)),
      stim(OP_BIT, 8'h00, 4'd0, WidthMax, 1'b1, bit_res(1'b0, 8'h50, 1'b0)),
      stim(OP_BIT, 8'h00, 4'd0, 16'd3),
      stim(OP_BIT, 8'h00, 4'd0, 16'd200),
      stim(OP_BIT, 8'h00, 4'd0, 16'd1),
      stim(OP_BIT, 8'h00, 4'd0, 16'd15),
      stim(OP_SEND, 8'h00, 4'd0, 16'd0),
      stim(OP_SEND, 8'hFF, 4'd0, 16'd0),
      stim(OP_SEND, 8'hA5, 4'd0, 16'd0),
      stim(OpFirstUnused, 8'hFF, 4'hF, WidthMax),
      stim(OpMidUnused, 8'h00, 4'd0, 16'd0),
      stim(OpLastUnused, 8'h5A, 4'd3, 16'd99),
      stim(OP_READ, 8'h00, 4'd1, 16'd0),
      stim(OP_READ, 8'h00, 4'd8, 16'd0),
      // Saturates to eight bytes and runs into the slot budget part way.
      stim(OP_READ, 8'hFF, 4'hF, WidthMax),
      stim(OP_SEND, 8'h3C, 4'd0, 16'd0, 1'b1, status_res(ST_OVERFLOW)),
      stim(OP_CLEAR, 8'h00, 4'd0, 16'd0, 1'b1, status_res(ST_OK)),
      stim(OP_READ, 8'h00, 4'd9, 16'd0)
    };

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        1: begin
          drain_results();
          sender_idle_pct = 69;
          stall_pct       = 0;
          load_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        end
        2: begin
          drain_results();
          sender_idle_pct = 0;
          stall_pct       = 69;
          load_timing(WidthMax, WidthMax, WidthMax, WidthMax, WidthMax);
        end
        3: begin
          drain_results();
          sender_idle_pct = 16;
          stall_pct       = 16;
          load_timing(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
        end
        default: begin
          sender_idle_pct = 0;
          stall_pct       = 0;
          foreach (directed[r]) begin
            push_item(directed[r].op, directed[r].data, directed[r].cnt, directed[r].cap);
            if (directed[r].typed) begin
              awaited_results.push_back(directed[r].want);
            end else begin
              foreach (item_results[i]) awaited_results.push_back(item_results[i]);
            end
          end
        end
      endcase

      // Mostly slot traffic and bit captures so the slot budget and byte assembly
      // are exercised deep; clears are rare enough that overflow happens.
      accepted = 0;
      while (accepted < ItemsPerPhase) begin
        pick = $urandom_range(99);
        data = 8'($urandom);
        cnt  = ($urandom_range(9) < 7) ? 4'($urandom_range(2, 1)) : 4'($urandom_range(15));
        if (pick < 3) op = OP_CLEAR;
        else if (pick < 31) op = OP_SEND;
        else if (pick < 45) op = OP_READ;
        else if (pick < 80) op = OP_BIT;
        else if (pick < 92) op = OP_PRESENCE;
        else op = 3'($urandom_range(OpLastUnused, OpFirstUnused));
        // Aim captures at the barrier that decides them.
        bar = (op == OP_PRESENCE) ? pres_bar : bit_bar;
        case ($urandom_range(3))
          0: cap = bar - 16'd1;
          1: cap = bar;
          2: cap = bar + 16'd1;
          default: cap = 16'($urandom);
        endcase
        push_item(op, data, cnt, cap);
        foreach (item_results[i]) awaited_results.push_back(item_results[i]);
        if (op <= OP_PRESENCE) accepted++;
      end
    end

    drain_results();
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("onewire_slot_codec_unit test passed");
    end else begin
      $display("onewire_slot_codec_unit test failed");
    end
    $finish;
  end

endmodule
